>>> rtl/core/rtcm_pkg.sv
// ----------------------------------------------------------------------------
// rtcm_pkg: shared types and constants of the three-wire RTC register master
// Phase codes, request codes, register indexes, command bits and the item
// and result records that pass between the sequencer and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtcm_pkg;

  // pin sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_GUARD_ON  = 3'd1,
    PH_SEND_LOW  = 3'd2,
    PH_SEND_HIGH = 3'd3,
    PH_READ_LOW  = 3'd4,
    PH_READ_HIGH = 3'd5,
    PH_GUARD_OFF = 3'd6
  } phase_t;

  // request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // configuration register indexes
  localparam logic CFG_HALF_BIT = 1'b0;
  localparam logic CFG_GUARD    = 1'b1;

  // command byte marks
  localparam logic [7:0] CMD_WRITE = 8'h80;
  localparam logic [7:0] CMD_READ  = 8'h81;

  // reset values of the timing registers
  localparam logic [7:0] HALF_BIT_RESET = 8'd1;
  localparam logic [7:0] GUARD_RESET    = 8'd1;

  // bit counts that end the command byte and the whole frame
  localparam logic [4:0] BITS_CMD   = 5'd8;
  localparam logic [4:0] BITS_FRAME = 5'd16;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] reg_addr;
    logic [7:0] wr_data;
    logic       io_in;
  } item_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_data;
    logic       rejected;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/rtcm_req_if.sv
// ----------------------------------------------------------------------------
// rtcm_req_if: request channel
// Valid/ready channel that carries one tick item to the RTC master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rtcm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [5:0] reg_addr;
  logic [7:0] wr_data;
  logic       io_in;

  modport source (output valid, output req_type, output reg_addr, output wr_data,
                  output io_in, input ready);
  modport sink (input valid, input req_type, input reg_addr, input wr_data,
                input io_in, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rtcm_res_if.sv
// ----------------------------------------------------------------------------
// rtcm_res_if: result channel
// Valid/ready channel that carries the pin levels and status of one tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rtcm_res_if;
  logic       valid;
  logic       ready;
  logic       chip_enable;
  logic       serial_clock;
  logic       io_out;
  logic       io_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rd_data;
  logic       rejected;

  modport source (output valid, output chip_enable, output serial_clock, output io_out,
                  output io_drive, output busy_res, output done_res, output rd_data,
                  output rejected, input ready);
  modport sink (input valid, input chip_enable, input serial_clock, input io_out,
                input io_drive, input busy_res, input done_res, input rd_data,
                input rejected, output ready);
endinterface

`default_nettype wire

>>> rtl/core/three_wire_rtc_register_master.sv
// ----------------------------------------------------------------------------
// three_wire_rtc_register_master: three-wire RTC link master, one register
// Drives chip enable, serial clock and the data line for single register
// writes and reads, one tick item at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one tick per item: a request code (plain tick, write, read),
//   the register address, the write byte and the sampled data pin level.
//   res returns one item per tick with the pin levels to drive, busy, done,
//   the read byte (on the done tick of a read) and a reject flag for a
//   request that arrived while a transaction was running.
//   cfg_we/cfg_index/cfg_wdata write half_bit_ticks (index 0) and
//   enable_guard_ticks (index 1); write them only while no item is in flight.
//   A running transaction takes the new lengths from its next tick on.
// Timing:
//   An item is registered in the input register on acceptance, and its result
//   is registered in the result register when the sequencer steps on it. One item is
//   accepted every cycle while res is taken: the input register and the result register form a
//   two-stage pipeline set by the single-tick sequencer update.
// Reset:
//   rst (synchronous) puts the link in idle with all pins low, the driver
//   off, both pipeline stages empty and both timing registers at 1.
// Stall:
//   When res is not taken the result holds, the input register fills, and
//   req.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module three_wire_rtc_register_master (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  rtcm_req_if.sink        req,
  rtcm_res_if.source      res
);

  logic [7:0]        half_bit_ticks;
  logic [7:0]        enable_guard_ticks;
  logic              item_valid;
  rtcm_pkg::item_t   item;
  logic              step;
  rtcm_pkg::result_t step_result;
  logic              res_valid;
  rtcm_pkg::result_t res_data;

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_bit_ticks     <= rtcm_pkg::HALF_BIT_RESET;
      enable_guard_ticks <= rtcm_pkg::GUARD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtcm_pkg::CFG_HALF_BIT: half_bit_ticks     <= cfg_wdata;
        rtcm_pkg::CFG_GUARD:    enable_guard_ticks <= cfg_wdata;
        default:                half_bit_ticks     <= half_bit_ticks;
      endcase
    end
  end

  // advance the sequencer when an item waits and the result slot frees
  assign step      = item_valid && (!res_valid || res.ready);
  assign req.ready = !item_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.req_type <= req.req_type;
      item.reg_addr <= req.reg_addr;
      item.wr_data  <= req.wr_data;
      item.io_in    <= req.io_in;
    end
  end

  rtcm_seq u_seq (
    .clk                (clk),
    .rst                (rst),
    .step               (step),
    .item               (item),
    .half_bit_ticks     (half_bit_ticks),
    .enable_guard_ticks (enable_guard_ticks),
    .result             (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_data <= step_result;
    end
  end

  assign res.valid        = res_valid;
  assign res.chip_enable  = res_data.chip_enable;
  assign res.serial_clock = res_data.serial_clock;
  assign res.io_out       = res_data.io_out;
  assign res.io_drive     = res_data.io_drive;
  assign res.busy_res     = res_data.busy_res;
  assign res.done_res     = res_data.done_res;
  assign res.rd_data      = res_data.rd_data;
  assign res.rejected     = res_data.rejected;

endmodule

`default_nettype wire

>>> rtl/core/rtcm_seq.sv
// ----------------------------------------------------------------------------
// rtcm_seq: pin sequencer of the RTC master
// Holds the transaction state and advances it by one tick whenever step is
// high, producing the pin levels and status of that tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtcm_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire rtcm_pkg::item_t  item,
  input  wire logic [7:0]       half_bit_ticks,
  input  wire logic [7:0]       enable_guard_ticks,
  output rtcm_pkg::result_t     result
);

  rtcm_pkg::phase_t phase, phase_next;
  logic [4:0]  bit_count, bit_count_next;
  logic [7:0]  tick_count, tick_count_next;
  logic [15:0] out_shift, out_shift_next;
  logic [7:0]  in_shift, in_shift_next;
  logic        is_read, is_read_next;
  logic        ce, ce_next;
  logic        sclk, sclk_next;
  logic        io, io_next;
  logic        drive, drive_next;

  logic        start;
  logic        finished;
  logic        reject;
  logic [4:0]  bc_inc;
  logic [7:0]  phase_len;
  logic [7:0]  cmd_byte;

  // state registers, advanced once per tick item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= rtcm_pkg::PH_IDLE;
      bit_count  <= '0;
      tick_count <= '0;
      out_shift  <= '0;
      in_shift   <= '0;
      is_read    <= 1'b0;
      ce         <= 1'b0;
      sclk       <= 1'b0;
      io         <= 1'b0;
      drive      <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      tick_count <= tick_count_next;
      out_shift  <= out_shift_next;
      in_shift   <= in_shift_next;
      is_read    <= is_read_next;
      ce         <= ce_next;
      sclk       <= sclk_next;
      io         <= io_next;
      drive      <= drive_next;
    end
  end

  assign start  = (item.req_type == rtcm_pkg::REQ_WRITE) ||
                  (item.req_type == rtcm_pkg::REQ_READ);
  assign bc_inc = bit_count + 5'd1;

  // length of the current phase; a zero half bit counts as one
  always_comb begin
    if (phase == rtcm_pkg::PH_GUARD_ON || phase == rtcm_pkg::PH_GUARD_OFF) begin
      phase_len = enable_guard_ticks;
    end else if (half_bit_ticks == 8'd0) begin
      phase_len = 8'd1;
    end else begin
      phase_len = half_bit_ticks;
    end
  end

  // command byte: address in bits 1 to 6, read flag in bit 0
  assign cmd_byte = ((item.req_type == rtcm_pkg::REQ_READ) ? rtcm_pkg::CMD_READ
                                                            : rtcm_pkg::CMD_WRITE)
                    | {1'b0, item.reg_addr, 1'b0};

  // next state of one tick
  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    tick_count_next = tick_count;
    out_shift_next  = out_shift;
    in_shift_next   = in_shift;
    is_read_next    = is_read;
    ce_next         = ce;
    sclk_next       = sclk;
    io_next         = io;
    drive_next      = drive;
    finished        = 1'b0;
    reject          = 1'b0;

    if (phase == rtcm_pkg::PH_IDLE) begin
      // open a transaction: raise chip enable and load the frame
      if (start) begin
        is_read_next    = (item.req_type == rtcm_pkg::REQ_READ);
        out_shift_next  = (item.req_type == rtcm_pkg::REQ_READ) ? {8'h00, cmd_byte}
                                                                 : {item.wr_data, cmd_byte};
        in_shift_next   = '0;
        bit_count_next  = '0;
        ce_next         = 1'b1;
        sclk_next       = 1'b0;
        phase_next      = rtcm_pkg::PH_GUARD_ON;
        tick_count_next = 8'd1;
        // no guard: place the first command bit at once
        if (enable_guard_ticks == 8'd0) begin
          drive_next = 1'b1;
          io_next    = cmd_byte[0];
          phase_next = rtcm_pkg::PH_SEND_LOW;
        end
      end
    end else begin
      reject = start;
      if (tick_count < phase_len) begin
        tick_count_next = tick_count + 8'd1;
      end else begin
        tick_count_next = 8'd1;
        unique case (phase)
          rtcm_pkg::PH_GUARD_ON: begin
            drive_next = 1'b1;
            sclk_next  = 1'b0;
            io_next    = out_shift[bit_count[3:0]];
            phase_next = rtcm_pkg::PH_SEND_LOW;
          end
          rtcm_pkg::PH_SEND_LOW: begin
            sclk_next  = 1'b1;
            phase_next = rtcm_pkg::PH_SEND_HIGH;
          end
          rtcm_pkg::PH_SEND_HIGH: begin
            sclk_next      = 1'b0;
            bit_count_next = bc_inc;
            // set the data line high at each byte end, unless another bit follows
            if (bc_inc[2:0] == 3'd0) begin
              io_next = 1'b1;
            end
            if (bc_inc < (is_read ? rtcm_pkg::BITS_CMD : rtcm_pkg::BITS_FRAME)) begin
              drive_next = 1'b1;
              io_next    = out_shift[bc_inc[3:0]];
              phase_next = rtcm_pkg::PH_SEND_LOW;
            end else if (is_read) begin
              drive_next = 1'b0;
              phase_next = rtcm_pkg::PH_READ_LOW;
            end else begin
              phase_next = rtcm_pkg::PH_GUARD_OFF;
              if (enable_guard_ticks == 8'd0) begin
                ce_next         = 1'b0;
                phase_next      = rtcm_pkg::PH_IDLE;
                tick_count_next = '0;
                finished        = 1'b1;
              end
            end
          end
          rtcm_pkg::PH_READ_LOW: begin
            // sample the data pin, then raise the clock or close
            if (item.io_in) begin
              in_shift_next[bit_count[2:0]] = 1'b1;
            end
            bit_count_next = bc_inc;
            if (bc_inc < rtcm_pkg::BITS_FRAME) begin
              sclk_next  = 1'b1;
              phase_next = rtcm_pkg::PH_READ_HIGH;
            end else begin
              sclk_next  = 1'b0;
              phase_next = rtcm_pkg::PH_GUARD_OFF;
              if (enable_guard_ticks == 8'd0) begin
                ce_next         = 1'b0;
                phase_next      = rtcm_pkg::PH_IDLE;
                tick_count_next = '0;
                finished        = 1'b1;
              end
            end
          end
          rtcm_pkg::PH_READ_HIGH: begin
            drive_next = 1'b0;
            sclk_next  = 1'b0;
            phase_next = rtcm_pkg::PH_READ_LOW;
          end
          default: begin
            // end of the closing guard, or a code with no meaning
            ce_next         = 1'b0;
            sclk_next       = 1'b0;
            phase_next      = rtcm_pkg::PH_IDLE;
            tick_count_next = '0;
            finished        = 1'b1;
          end
        endcase
      end
    end
  end

  // result of this tick
  always_comb begin
    result.chip_enable  = ce_next;
    result.serial_clock = sclk_next;
    result.io_out       = io_next;
    result.io_drive     = drive_next;
    result.busy_res     = (phase_next != rtcm_pkg::PH_IDLE);
    result.done_res     = finished;
    result.rd_data      = (finished && is_read_next) ? in_shift_next : 8'h00;
    result.rejected     = reject;
  end

endmodule

`default_nettype wire
